// ===== rtl/fat12_pkg.sv =====
// fat12 cluster table engine package: payload structs, func codes, constants
// no dependencies
`timescale 1ns / 1ps
package fat12_pkg;
  localparam int MAX_CLUSTERS_DEF = 4096;
  localparam logic [12:0] CLUSTER_COUNT_RST = 13'd2845;
  localparam logic [11:0] END_MARK = 12'hFF8;

  localparam logic [2:0] FN_LOAD  = 3'd0;
  localparam logic [2:0] FN_READ  = 3'd1;
  localparam logic [2:0] FN_GET   = 3'd2;
  localparam logic [2:0] FN_SET   = 3'd3;
  localparam logic [2:0] FN_ALLOC = 3'd4;
  localparam logic [2:0] FN_FREE  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_CHAIN = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [12:0] byte_index;
    logic [7:0]  byte_data;
    logic [11:0] cluster;
    logic [11:0] entry_value;
    logic [11:0] link_from;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [11:0] entry_out;
    logic [11:0] new_cluster;
    logic [12:0] freed_count;
    logic [1:0]  status;
  } rsp_t;
endpackage

// ===== rtl/fat12_cluster_table_engine_core.sv =====
// fat12 cluster table engine top level
// depends on fat12_pkg and fat12_ram
`timescale 1ns / 1ps
// FAT12 allocation table held as packed bytes in one single-port ram with
// registered read. start is taken when busy is low; each command gives
// exactly one result, shown with done high for one cycle, and the receiver
// cannot stall it. the single port is the bottleneck, so ram accesses go one
// at a time. load writes one byte; read byte reads one byte (none when the
// index is past the table); get entry reads the two bytes of the entry; set
// entry reads both bytes, checks, then writes both bytes; allocate reads each
// scanned cluster, then writes the end mark and, if asked, reads and writes
// the link; free chain reads and clears each freed cluster. done shows in
// the cycle after the last busy cycle, and a new start can be taken in that
// same cycle. there is no clearing pass; bytes are undefined until loaded.
module fat12_cluster_table_engine_core #(
  parameter int MAX_CLUSTERS = fat12_pkg::MAX_CLUSTERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  fat12_pkg::cmd_t     cmd,
  output logic                done,
  output fat12_pkg::rsp_t     rsp,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_wdata
);
  import fat12_pkg::*;

  localparam int DEPTH = (MAX_CLUSTERS * 3) / 2 + 1;
  localparam int AW = $clog2(DEPTH);
  localparam rsp_t RSP_FULL = '{status: ST_FULL, default: '0};
  localparam rsp_t RSP_CHAIN = '{status: ST_CHAIN, default: '0};

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_EVAL, S_WR0, S_WR1, S_DONE
  } state_t;

  // what the current entry access is for
  typedef enum logic [2:0] {
    P_GET, P_SET, P_SCAN, P_MARK, P_LINK, P_FREE
  } phase_t;

  state_t state;
  phase_t phase;
  cmd_t   c;
  rsp_t   r;
  logic [12:0] count_reg;
  logic [12:0] lim;
  logic [11:0] cur;      // entry being accessed
  logic [11:0] wval;     // value to write into entry cur
  logic [11:0] scan;
  logic [7:0]  b0;       // low byte of the entry word
  logic [7:0]  b1;       // high byte of the entry word
  logic [13:0] off_w;
  logic        we;
  logic [AW-1:0] addr;
  logic [7:0]  wdata, rdata;
  logic [11:0] ent;
  logic        free_ok;

  assign lim = (count_reg > 13'(MAX_CLUSTERS)) ? 13'(MAX_CLUSTERS) : count_reg;
  assign off_w = 14'(cur) + 14'(cur[11:1]);
  assign ent = cur[0] ? {b1, b0[7:4]} : {b1[3:0], b0};
  // first cluster of a chain is a real link
  assign free_ok = (cmd.cluster >= 12'd2) && (cmd.cluster < END_MARK) &&
                   (32'(cmd.cluster) < MAX_CLUSTERS);

  fat12_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // ram port steering
  always_comb begin
    we = 1'b0;
    addr = AW'(off_w);
    wdata = 8'h00;
    case (state)
      S_RD0: begin
        if (phase == P_GET && (c.func == FN_LOAD || c.func == FN_READ)) begin
          addr = AW'(c.byte_index);
          // loads past the table are dropped
          we = (c.func == FN_LOAD) && (c.byte_index < 13'(DEPTH));
          wdata = c.byte_data;
        end
      end
      S_RD1: addr = AW'(off_w + 14'd1);
      S_WR0: begin
        we = 1'b1;
        wdata = cur[0] ? {wval[3:0], b0[3:0]} : wval[7:0];
      end
      S_WR1: begin
        we = 1'b1;
        addr = AW'(off_w + 14'd1);
        wdata = cur[0] ? wval[11:4] : {b1[7:4], wval[11:8]};
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      count_reg <= CLUSTER_COUNT_RST;
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) count_reg <= cfg_wdata;
      case (state)
        S_IDLE: begin
          if (start) begin
            c <= cmd;
            case (cmd.func)
              FN_LOAD: begin
                r <= '0;
                phase <= P_GET;
                state <= S_RD0;
              end
              FN_READ: begin
                r <= '0;
                phase <= P_GET;
                state <= (cmd.byte_index < 13'(DEPTH)) ? S_RD0 : S_DONE;
              end
              FN_GET: begin
                r <= '0;
                phase <= P_GET;
                cur <= cmd.cluster;
                state <= (32'(cmd.cluster) < MAX_CLUSTERS) ? S_RD0 : S_DONE;
              end
              FN_SET: begin
                r <= '0;
                cur <= cmd.cluster;
                wval <= cmd.entry_value;
                phase <= P_SET;
                state <= (32'(cmd.cluster) < MAX_CLUSTERS) ? S_RD0 : S_DONE;
              end
              FN_ALLOC: begin
                r <= RSP_FULL;
                cur <= 12'd2;
                scan <= 12'd2;
                phase <= P_SCAN;
                state <= (lim > 13'd2) ? S_RD0 : S_DONE;
              end
              FN_FREE: begin
                cur <= cmd.cluster;
                phase <= P_FREE;
                if (free_ok) begin
                  // a zero count overruns before the first cluster
                  r <= (lim == 13'd0) ? RSP_CHAIN : '0;
                  state <= (lim == 13'd0) ? S_DONE : S_RD0;
                end else begin
                  r <= '0;
                  state <= S_DONE;
                end
              end
              default: begin
                r <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD0: begin
          if (c.func == FN_LOAD) state <= S_DONE;
          else if (c.func == FN_READ) state <= S_RD2;
          else state <= S_RD1;
        end
        S_RD1: begin
          // first byte arrives here
          b0 <= rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          // table byte for read byte, else second byte of the entry
          if (c.func == FN_READ) begin
            r.read_byte <= rdata;
            state <= S_DONE;
          end else begin
            b1 <= rdata;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          // full entry on ent
          case (phase)
            P_GET: begin
              r.entry_out <= ent;
              state <= S_DONE;
            end
            P_SCAN: begin
              if (ent == 12'd0) begin
                phase <= P_MARK;
                wval <= END_MARK;
                state <= S_WR0;
              end else if (13'(scan) + 13'd1 < lim) begin
                scan <= scan + 12'd1;
                cur <= scan + 12'd1;
                state <= S_RD0;
              end else state <= S_DONE;
            end
            P_FREE: begin
              wval <= 12'd0;
              scan <= ent;  // next link
              state <= S_WR0;
            end
            default: state <= S_WR0;  // set, link
          endcase
        end
        S_WR0: state <= S_WR1;
        S_WR1: begin
          case (phase)
            P_MARK: begin
              r.new_cluster <= cur;
              r.status <= ST_OK;
              if (c.link_from != 12'd0 && 32'(c.link_from) < MAX_CLUSTERS) begin
                phase <= P_LINK;
                wval <= cur;
                cur <= c.link_from;
                state <= S_RD0;
              end else state <= S_DONE;
            end
            P_FREE: begin
              r.freed_count <= r.freed_count + 13'd1;
              cur <= scan;
              if (!(scan >= 12'd2 && scan < END_MARK &&
                    32'(scan) < MAX_CLUSTERS)) state <= S_DONE;
              else if (r.freed_count + 13'd1 >= lim) begin
                r.status <= ST_CHAIN;
                state <= S_DONE;
              end else state <= S_RD0;
            end
            default: state <= S_DONE;
          endcase
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp = r;

  // a result strobe ends every command and frees the block
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  // done is raised only after the done state
  a_done_prev: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_DONE)) else $error("spurious done");
  // allocate reports success only with a cluster number of at least 2
  a_alloc: assert property (@(posedge clk) disable iff (rst)
    (done && c.func == FN_ALLOC && r.status == ST_OK) |-> r.new_cluster >= 12'd2)
    else $error("bad allocate result");
endmodule

// ===== rtl/fat12_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module fat12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 6144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
